>>> rtl/core/cs_pkg.sv
// ----------------------------------------------------------------------------
// cs_pkg: shared types and functions for the ChaCha20 stream XOR block
// Payload structs, tagged queue entry, state codes and the round function.
// ----------------------------------------------------------------------------
`default_nettype none

package cs_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned RoundCount = 20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       result_last;
  } result_t;

  // item tagged by the front with its keystream position and block number
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [5:0]  pos;
    logic [31:0] counter;
    logic        gen;
  } tag_t;

  typedef struct packed {
    logic [5:0]  pos;
    logic [31:0] counter;
  } front_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROUND,
    B_ADD
  } back_state_t;

  typedef struct packed {
    back_state_t state;
    logic        head_gen;
  } back_status_t;

  typedef enum logic [2:0] {
    CFG_KEY0  = 3'd0,
    CFG_KEY1  = 3'd1,
    CFG_KEY2  = 3'd2,
    CFG_KEY3  = 3'd3,
    CFG_NONCE_LO = 3'd4,
    CFG_NONCE_HI = 3'd5
  } cfg_index_t;

  typedef logic [15:0][31:0] words_t;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646E;
  localparam logic [31:0] Sigma2 = 32'h79622D32;
  localparam logic [31:0] Sigma3 = 32'h6B206574;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] quarter(input logic [31:0] a0, input logic [31:0] b0,
                                           input logic [31:0] c0, input logic [31:0] d0);
    logic [31:0] a, b, c, d;
    a = a0; b = b0; c = c0; d = d0;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    quarter = {a, b, c, d};
  endfunction

  // one column round (diag low) or one diagonal round (diag high)
  function automatic words_t half_round(input words_t w, input logic diag);
    words_t r;
    logic [127:0] q;
    int unsigned i;
    r = w;
    for (i = 0; i < 4; i++) begin
      if (!diag) begin
        q = quarter(w[i], w[4 + i], w[8 + i], w[12 + i]);
        {r[i], r[4 + i], r[8 + i], r[12 + i]} = q;
      end else begin
        q = quarter(w[i], w[4 + ((i + 1) % 4)], w[8 + ((i + 2) % 4)], w[12 + ((i + 3) % 4)]);
        {r[i], r[4 + ((i + 1) % 4)], r[8 + ((i + 2) % 4)], r[12 + ((i + 3) % 4)]} = q;
      end
    end
    half_round = r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cs_front.sv
// ----------------------------------------------------------------------------
// cs_front: input side
// Tracks byte position and block number, tags each item, and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module cs_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  cs_pkg::item_t   item,
  output cs_pkg::tag_t    head,
  output logic            head_valid,
  input  logic            head_pop,
  output cs_pkg::front_status_t status
);
  import cs_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  tag_t              q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     count;
  logic [5:0]        pos;
  logic [31:0]       counter;
  logic              accept;
  tag_t              tag;

  assign full       = (count == (PtrW+1)'(QueueDepth));
  assign accept     = push && !full;
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];
  assign status     = '{pos: pos, counter: counter};

  always_comb begin
    tag.data_byte = item.data_byte;
    tag.last_byte = item.last_byte;
    tag.pos       = pos;
    tag.counter   = counter;
    tag.gen       = (pos == '0);   // first byte of a block needs a fresh block
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      pos     <= '0;
      counter <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
        if (item.last_byte) begin
          pos     <= '0;
          counter <= '0;
        end else begin
          pos <= pos + 1'b1;
          if (pos == 6'd63) begin
            counter <= counter + 1'b1;
          end
        end
      end
      if (head_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PtrW+1)'(accept) - (PtrW+1)'(head_pop);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cs_back.sv
// ----------------------------------------------------------------------------
// cs_back: keystream and output side
// Runs the rounds on demand, holds the block, XORs bytes into the result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module cs_back (
  input  logic                clk,
  input  logic                rst,
  input  cs_pkg::tag_t        head,
  input  logic                head_valid,
  output logic                head_pop,
  input  logic [3:0][63:0]    key,
  input  logic [63:0]         nonce_low,
  input  logic [31:0]         nonce_high,
  output logic                empty,
  input  logic                pop,
  output cs_pkg::result_t     result,
  output cs_pkg::back_status_t status
);
  import cs_pkg::*;

  back_state_t       state, state_next;
  logic [4:0]        round, round_next;
  words_t            w, w_next;
  words_t            init;
  logic [7:0][63:0]  block;
  logic              gen_done, gen_done_next;
  logic              out_valid;
  result_t           out_reg;
  logic              out_free;
  logic              load_block;
  logic [63:0]       ks_word;
  logic [7:0]        ks_byte;

  always_comb begin
    init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2*i] = key[i][31:0];
      init[5 + 2*i] = key[i][63:32];
    end
    init[12] = head.counter;
    init[13] = nonce_low[31:0];
    init[14] = nonce_low[63:32];
    init[15] = nonce_high;
  end

  assign out_free = !out_valid || pop;
  assign ks_word  = block[head.pos[5:3]];
  assign ks_byte  = ks_word[{head.pos[2:0], 3'b000} +: 8];
  assign empty    = !out_valid;
  assign result   = out_reg;
  assign status   = '{state: state, head_gen: head.gen};

  always_comb begin
    state_next    = state;
    round_next    = round;
    w_next        = w;
    gen_done_next = gen_done;
    head_pop      = 1'b0;
    load_block    = 1'b0;
    case (state)
      B_IDLE: begin
        if (head_valid) begin
          if (head.gen && !gen_done) begin
            w_next     = init;
            round_next = '0;
            state_next = B_ROUND;
          end else if (out_free) begin
            head_pop      = 1'b1;
            gen_done_next = 1'b0;
          end
        end
      end
      B_ROUND: begin
        w_next     = half_round(w, round[0]);
        round_next = round + 1'b1;
        if (round == 5'(RoundCount - 1)) begin
          state_next = B_ADD;
        end
      end
      B_ADD: begin
        load_block    = 1'b1;
        gen_done_next = 1'b1;
        state_next    = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      gen_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      gen_done <= gen_done_next;
      if (head_pop) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    round <= round_next;
    w     <= w_next;
    if (load_block) begin
      for (int i = 0; i < 8; i++) begin
        block[i] <= {w[2*i+1] + init[2*i+1], w[2*i] + init[2*i]};
      end
    end
    if (head_pop) begin
      out_reg.result_byte <= head.data_byte ^ ks_byte;
      out_reg.result_last <= head.last_byte;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/chacha20_stream_xor.sv
// ----------------------------------------------------------------------------
// chacha20_stream_xor: ChaCha20 (20 rounds) byte-stream XOR
// Key and nonce in config registers; one result byte per input byte.
// ----------------------------------------------------------------------------
// Each pushed byte is XORed with the next ChaCha20 keystream byte; the block
// counter starts at 0 per message and steps every 64 bytes. A byte that
// does not start a 64-byte block is XORed from the held block without new
// rounds; the first byte of each block waits while the state is loaded,
// the shared round unit does one column or diagonal round per cycle and the
// feed-forward add. The front queue holds two bytes, and a finished result
// waits in the output register while the next byte is worked on. A transfer
// with last_byte set ends the message. Key and nonce may be written only when
// the block is idle; a write lands in the next block generated.
`default_nettype none

module chacha20_stream_xor (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  cs_pkg::item_t     item,
  output logic              empty,
  input  logic              pop,
  output cs_pkg::result_t   result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import cs_pkg::*;

  logic [3:0][63:0] key;
  logic [63:0]      nonce_low;
  logic [31:0]      nonce_high;
  tag_t             head;
  logic             head_valid;
  logic             head_pop;
  front_status_t    fstat;
  back_status_t     bstat;

  // config always taken; out-of-range indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key        <= '0;
      nonce_low  <= '0;
      nonce_high <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KEY0:     key[0]     <= cfg_data;
        CFG_KEY1:     key[1]     <= cfg_data;
        CFG_KEY2:     key[2]     <= cfg_data;
        CFG_KEY3:     key[3]     <= cfg_data;
        CFG_NONCE_LO: nonce_low  <= cfg_data;
        CFG_NONCE_HI: nonce_high <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  cs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .status     (fstat)
  );

  cs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .key        (key),
    .nonce_low  (nonce_low),
    .nonce_high (nonce_high),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .status     (bstat)
  );

  // a last-byte transfer restarts the message position
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    push && !full && item.last_byte |=> fstat.pos == '0 && fstat.counter == '0)
    else $error("message position not restarted after last byte");

  // rounds only ever run for a byte that opens a block
  a_round_for_gen: assert property (@(posedge clk) disable iff (rst)
    bstat.state == B_ROUND |-> head_valid && bstat.head_gen)
    else $error("round unit busy without a block-opening byte");

  // no result transfer is produced while a block is being generated
  a_no_pop_in_rounds: assert property (@(posedge clk) disable iff (rst)
    bstat.state == B_ROUND |-> !head_pop)
    else $error("byte consumed during block generation");

endmodule

`default_nettype wire
